// ===== rtl/rv32im_execute_step_defines.svh =====
// ----------------------------------------------------------------------------
// rv32im_execute_step_defines
// Assertion macros used by rvx_control.
// ----------------------------------------------------------------------------
`ifndef RV32IM_EXECUTE_STEP_DEFINES_SVH
`define RV32IM_EXECUTE_STEP_DEFINES_SVH

// Assert that an implication holds at every clock edge outside reset.
`define RVX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that a consequent holds in the cycle after its antecedent.
`define RVX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rvx_pkg.sv =====
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants of the RV32IM execute step.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_FENCE  = 7'h0F;

  localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
  localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
  localparam logic [31:0] START_PC_RESET = 32'h8000_0000;
  localparam logic [4:0]  REG_A0 = 5'd10;

  // commands from controller to datapath
  typedef struct packed {
    logic latch_insn;  // capture instruction, read rs1/rs2
    logic exec;        // decode and compute, launch multiply/divide
    logic mem_step;    // one byte of a load or store
    logic commit;      // write back, update pc, load output register
    logic halt_out;    // build the result of a stopped core
  } rvx_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic need_mem;
    logic mem_last;
  } rvx_sts_t;

endpackage

// ===== rtl/rvx_divider.sv =====
// ----------------------------------------------------------------------------
// rvx_divider
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rvx_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[32]) begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/rvx_datapath.sv =====
// ----------------------------------------------------------------------------
// rvx_datapath
// Register file, pc, data memory, ALU, multiplier and result register.
// ----------------------------------------------------------------------------
module rvx_datapath #(
  parameter int DATA_MEM_BYTES = 16384
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rvx_pkg::rvx_cmd_t cmd,
  output rvx_pkg::rvx_sts_t sts,
  input  logic [31:0]     instruction,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_data,
  output logic [31:0]     out_this_pc,
  output logic [31:0]     out_following_pc,
  output logic            out_reg_write,
  output logic [4:0]      out_reg_index,
  output logic [31:0]     out_reg_value,
  output logic            out_halted,
  output logic [31:0]     out_exit_code,
  output logic            out_illegal
);
  import rvx_pkg::*;

  localparam int AW = $clog2(DATA_MEM_BYTES);

  logic [31:0] regs_r [32];
  logic [7:0]  mem_r [DATA_MEM_BYTES];
  logic [31:0] pc_r;
  logic        stopped_r, bad_r;
  logic [31:0] insn_r, a_r, b_r;

  logic [31:0] val_r, next_r, addr_r, mdata_r, sdata_r;
  logic        wr_r, bad_cur_r, halt_cur_r, is_load_r, is_store_r, sx_r;
  logic [1:0]  msize_r, bidx_r;
  logic        div_op_r, div_rem_r, div_neg_r, div_spec_r;
  logic [2:0]  mul_f3_r;
  logic        mul_op_r;
  logic [63:0] prod_r;
  logic [31:0] mag_a_r, mag_b_r;
  logic [7:0]  rdbyte_r;
  logic        div_start_r;
  logic        div_done;
  logic [31:0] quo, rem;
  logic        ld_shift_r;
  logic [1:0]  ld_pos_r;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [31:0] ii, iu, is_, ij, ib;
  logic        lts;

  assign opc = insn_r[6:0];
  assign f3  = insn_r[14:12];
  assign f7  = insn_r[31:25];
  assign rd  = insn_r[11:7];
  assign ii  = {{20{insn_r[31]}}, insn_r[31:20]};
  assign iu  = {insn_r[31:12], 12'h000};
  assign is_ = {{20{insn_r[31]}}, insn_r[31:25], insn_r[11:7]};
  assign ij  = {{11{insn_r[31]}}, insn_r[31], insn_r[19:12], insn_r[20], insn_r[30:21], 1'b0};
  assign ib  = {{19{insn_r[31]}}, insn_r[31], insn_r[7], insn_r[30:25], insn_r[11:8], 1'b0};
  assign lts = (a_r ^ START_PC_RESET) < (b_r ^ START_PC_RESET);

  // decode and compute
  logic [31:0] e_val, e_next, e_addr, opb;
  logic        e_wr, e_bad, e_halt, e_ld, e_st, e_sx, e_div, e_mul, e_take;
  logic [1:0]  e_size;
  logic [4:0]  sh;

  always_comb begin
    e_val = '0; e_next = pc_r + 32'd4; e_addr = a_r + ii; e_wr = 1'b0; e_bad = 1'b0;
    e_halt = 1'b0; e_ld = 1'b0; e_st = 1'b0; e_sx = 1'b0; e_size = 2'd0; e_div = 1'b0;
    e_mul = 1'b0; e_take = 1'b0;
    opb = (opc == OP_REG) ? b_r : ii;
    sh  = opb[4:0];
    case (opc)
      OP_LUI: begin e_wr = 1'b1; e_val = iu; end
      OP_AUIPC: begin e_wr = 1'b1; e_val = pc_r + iu; end
      OP_LOAD: begin
        case (f3)
          3'd0: begin e_ld = 1'b1; e_sx = 1'b1; e_size = 2'd0; end
          3'd1: begin e_ld = 1'b1; e_sx = 1'b1; e_size = 2'd1; end
          3'd2: begin e_ld = 1'b1; e_size = 2'd3; end
          3'd4: begin e_ld = 1'b1; e_size = 2'd0; end
          3'd5: begin e_ld = 1'b1; e_size = 2'd1; end
          default: e_bad = 1'b1;
        endcase
        e_wr = e_ld;
      end
      OP_STORE: begin
        e_addr = a_r + is_;
        case (f3)
          3'd0: begin e_st = 1'b1; e_size = 2'd0; end
          3'd1: begin e_st = 1'b1; e_size = 2'd1; end
          3'd2: begin e_st = 1'b1; e_size = 2'd3; end
          default: e_bad = 1'b1;
        endcase
      end
      OP_REG, OP_IMM: begin
        e_wr = 1'b1;
        if (opc == OP_REG && f7 == 7'h01) begin
          e_div = f3[2];
          e_mul = !f3[2];
        end else begin
          case (f3)
            3'd0: begin
              if (opc == OP_REG && f7 == 7'h20) e_val = a_r - opb;
              else if (opc == OP_REG && f7 != 7'h00) e_bad = 1'b1;
              else e_val = a_r + opb;
            end
            3'd1: begin
              if (f7 == 7'h00) e_val = a_r << sh;
              else e_bad = 1'b1;
            end
            3'd2: begin
              if (opc == OP_REG && f7 != 7'h00) e_bad = 1'b1;
              e_val = {31'd0, ((a_r ^ START_PC_RESET) < (opb ^ START_PC_RESET))};
            end
            3'd3: begin
              if (opc == OP_REG && f7 != 7'h00) e_bad = 1'b1;
              e_val = {31'd0, a_r < opb};
            end
            3'd4: begin
              if (opc == OP_REG && f7 != 7'h00) e_bad = 1'b1;
              e_val = a_r ^ opb;
            end
            3'd5: begin
              if (f7 == 7'h00) e_val = a_r >> sh;
              else if (f7 == 7'h20) e_val = $unsigned($signed(a_r) >>> sh);
              else e_bad = 1'b1;
            end
            3'd6: begin
              if (opc == OP_REG && f7 != 7'h00) e_bad = 1'b1;
              e_val = a_r | opb;
            end
            default: begin
              if (opc == OP_REG && f7 != 7'h00) e_bad = 1'b1;
              e_val = a_r & opb;
            end
          endcase
        end
      end
      OP_JAL: begin e_wr = 1'b1; e_val = pc_r + 32'd4; e_next = pc_r + ij; end
      OP_JALR: begin
        if (f3 == 3'd0) begin
          e_wr = 1'b1; e_val = pc_r + 32'd4; e_next = (a_r + ii) & ~32'd1;
        end else e_bad = 1'b1;
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: e_take = a_r == b_r;
          3'd1: e_take = a_r != b_r;
          3'd4: e_take = lts;
          3'd5: e_take = !lts;
          3'd6: e_take = a_r < b_r;
          3'd7: e_take = a_r >= b_r;
          default: e_bad = 1'b1;
        endcase
        if (e_take) e_next = pc_r + ib;
      end
      OP_SYSTEM: begin
        if (insn_r == INSN_ECALL || insn_r == INSN_EBREAK) e_halt = 1'b1;
        else e_bad = 1'b1;
      end
      OP_FENCE: if (f3 > 3'd1) e_bad = 1'b1;
      default: e_bad = 1'b1;
    endcase
    if (e_bad) begin
      e_wr = 1'b0; e_ld = 1'b0; e_st = 1'b0; e_div = 1'b0; e_mul = 1'b0;
    end
  end

  // multiplier operands: 33-bit signed each, product low 64 bits kept
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_full;
  logic        a_neg, b_neg, dspec_ovf, dzero;
  logic [31:0] x_val;
  assign a_neg = a_r[31] && !f3[0];
  assign b_neg = b_r[31] && !f3[0];
  assign ma = {(f3[1:0] != 2'd3) && a_r[31], a_r};
  assign mb = {(f3[1:0] == 2'd1) && b_r[31], b_r};
  assign prod_full = ma * mb;
  assign dzero = b_r == 32'd0;
  assign dspec_ovf = !f3[0] && a_r == START_PC_RESET && b_r == 32'hFFFF_FFFF;
  assign x_val = !e_div ? e_val :
                 dzero ? (f3[1] ? a_r : 32'hFFFF_FFFF) :
                 dspec_ovf ? (f3[1] ? 32'd0 : a_r) : e_val;

  rvx_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .dividend(mag_a_r), .divisor(mag_b_r),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  // DATA_MEM_BYTES must be a power of two, which the block does not check; the low bits select the byte
  logic [31:0]   maddr;
  logic [AW-1:0] baddr;
  assign maddr = addr_r + {30'd0, bidx_r};
  assign baddr = maddr[AW-1:0];

  logic [31:0] div_res, final_val, ld_val;
  always_comb begin
    if (div_spec_r) div_res = val_r;
    else if (div_rem_r) div_res = div_neg_r ? 32'd0 - rem : rem;
    else div_res = div_neg_r ? 32'd0 - quo : quo;
    case (msize_r)
      2'd0: ld_val = sx_r ? {{24{mdata_r[7]}}, mdata_r[7:0]} : {24'd0, mdata_r[7:0]};
      2'd1: ld_val = sx_r ? {{16{mdata_r[15]}}, mdata_r[15:0]} : {16'd0, mdata_r[15:0]};
      default: ld_val = mdata_r;
    endcase
    if (div_op_r) final_val = div_res;
    else if (mul_op_r) final_val = (mul_f3_r == 3'd0) ? prod_r[31:0] : prod_r[63:32];
    else if (is_load_r) final_val = ld_val;
    else final_val = val_r;
  end

  logic [4:0] rs1, rs2;
  assign rs1 = instruction[19:15];
  assign rs2 = instruction[24:20];

  always_ff @(posedge clk) begin
    rdbyte_r <= mem_r[baddr];
    if (cmd.mem_step && is_store_r)
      mem_r[baddr] <= sdata_r[7:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_insn) begin
      insn_r <= instruction;
      a_r <= regs_r[rs1];
      b_r <= regs_r[rs2];
    end
    if (cmd.exec) begin
      val_r <= x_val; next_r <= (e_halt || e_bad) ? pc_r + 32'd4 : e_next;
      addr_r <= e_addr; sdata_r <= b_r; mdata_r <= '0;
      wr_r <= e_wr && rd != 5'd0; bad_cur_r <= e_bad; halt_cur_r <= e_halt || e_bad;
      is_load_r <= e_ld; is_store_r <= e_st; sx_r <= e_sx; msize_r <= e_size;
      bidx_r <= 2'd0;
      div_op_r <= e_div; mul_op_r <= e_mul; mul_f3_r <= f3;
      div_rem_r <= f3[1];
      div_neg_r <= f3[1] ? a_neg : (a_neg != b_neg);
      div_spec_r <= dzero || dspec_ovf;
      mag_a_r <= a_neg ? 32'd0 - a_r : a_r;
      mag_b_r <= b_neg ? 32'd0 - b_r : b_r;
      prod_r <= prod_full[63:0];
    end
    if (cmd.mem_step) begin
      sdata_r <= {8'd0, sdata_r[31:8]};
      bidx_r <= bidx_r + 2'd1;
    end
    // byte read is registered; shift in when the previous step was a read
    if (ld_shift_r) mdata_r <= mdata_r | ({24'd0, rdbyte_r} << {ld_pos_r, 3'd0});
    if (cmd.commit || cmd.halt_out) begin
      out_this_pc      <= pc_r;
      out_following_pc <= cmd.halt_out ? pc_r : next_r;
      out_reg_write    <= cmd.halt_out ? 1'b0 : wr_r;
      out_reg_index    <= (cmd.halt_out || !wr_r) ? 5'd0 : rd;
      out_reg_value    <= (cmd.halt_out || !wr_r) ? 32'd0 : final_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ld_shift_r <= 1'b0;
    else ld_shift_r <= cmd.mem_step && is_load_r;
    ld_pos_r <= bidx_r;
  end

  logic [31:0] a0_now;
  assign a0_now = regs_r[REG_A0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) regs_r[i] <= '0;
      pc_r <= START_PC_RESET;
      stopped_r <= 1'b0;
      bad_r <= 1'b0;
      out_halted <= 1'b0;
      out_exit_code <= '0;
      out_illegal <= 1'b0;
    end else begin
      if (cfg_we) begin
        pc_r <= cfg_data;
      end
      if (cmd.commit) begin
        if (wr_r) regs_r[rd] <= final_val;
        if (!halt_cur_r) pc_r <= next_r;
        if (halt_cur_r) stopped_r <= 1'b1;
        if (bad_cur_r) bad_r <= 1'b1;
        out_halted <= halt_cur_r;
        out_exit_code <= halt_cur_r ? a0_now : 32'd0;
        out_illegal <= bad_r || bad_cur_r;
      end
      if (cmd.halt_out) begin
        out_halted <= 1'b1;
        out_exit_code <= a0_now;
        out_illegal <= bad_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) div_start_r <= 1'b0;
    else div_start_r <= cmd.exec && e_div && !(dzero || dspec_ovf);
  end

  assign sts.need_div = div_op_r && !div_spec_r;
  assign sts.div_done = div_done;
  assign sts.need_mem = (is_load_r || is_store_r) && !stopped_r;
  assign sts.mem_last = bidx_r == msize_r;

endmodule

// ===== rtl/rvx_control.sv =====
// ----------------------------------------------------------------------------
// rvx_control
// Sequencer: fetch word, execute, memory bytes, divide wait, commit, output.
// ----------------------------------------------------------------------------
module rvx_control (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic            stopped,
  output rvx_pkg::rvx_cmd_t cmd,
  input  rvx_pkg::rvx_sts_t sts
);
  import rvx_pkg::*;
  `include "rv32im_execute_step_defines.svh"

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MEM, S_LDW, S_DIV, S_COMMIT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  // a new word is taken only while the output register is free or being drained
  assign in_stall = !(state_r == S_IDLE && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd = '0;
    case (state_r)
      S_IDLE: if (accept) begin
        cmd.latch_insn = 1'b1;
        state_nxt = stopped ? S_COMMIT : S_READ;
      end
      S_READ: begin
        cmd.exec = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.need_mem) state_nxt = S_MEM;
        else if (sts.need_div) state_nxt = S_DIV;
        else state_nxt = S_COMMIT;
      end
      S_MEM: begin
        cmd.mem_step = 1'b1;
        if (sts.mem_last) state_nxt = S_LDW;
      end
      S_LDW: state_nxt = S_COMMIT;
      S_DIV: if (sts.div_done) state_nxt = S_COMMIT;
      S_COMMIT: begin
        if (stopped) cmd.halt_out = 1'b1;
        else cmd.commit = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RVX_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, in_stall,
    "word accepted while busy")
  `RVX_ASSERT_NXT(a_commit_valid, clk, rst_n, state_r == S_COMMIT, out_valid,
    "commit did not raise out_valid")
  `RVX_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd),
    "more than one command at once")

endmodule

// ===== rtl/rv32im_execute_step.sv =====
// ----------------------------------------------------------------------------
// rv32im_execute_step
// RV32IM instruction execute step with register file and byte data memory.
// ----------------------------------------------------------------------------
// One instruction word per item, one result word per item. ALU ops, jumps,
// branches and multiplies pass through the READ, EXEC and COMMIT states, and the
// next word can be accepted once the block is back in IDLE and the result is taken.
// Loads and stores add one S_MEM step per byte and the S_LDW wait state; divides
// and remainders, except by zero or signed overflow, wait on the one-bit-per-cycle
// divider. A stopped core goes from acceptance straight to COMMIT. The data
// memory is byte-wide, one port, one byte a cycle; DATA_MEM_BYTES must be a power
// of two. The output register is freed while its word is taken, so the next word
// may be accepted in that same cycle.
module rv32im_execute_step #(
  parameter int DATA_MEM_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_start_pc,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_this_pc,
  output logic [31:0] out_following_pc,
  output logic        out_reg_write,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic        out_halted,
  output logic [31:0] out_exit_code,
  output logic        out_illegal
);
  import rvx_pkg::*;

  rvx_cmd_t cmd;
  rvx_sts_t sts;

  assign cfg_ready = 1'b1;

  rvx_control u_ctl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stopped(out_halted),
    .cmd(cmd), .sts(sts)
  );

  rvx_datapath #(.DATA_MEM_BYTES(DATA_MEM_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .instruction(in_instruction),
    .cfg_we(cfg_valid), .cfg_data(cfg_start_pc),
    .out_this_pc(out_this_pc), .out_following_pc(out_following_pc),
    .out_reg_write(out_reg_write), .out_reg_index(out_reg_index),
    .out_reg_value(out_reg_value), .out_halted(out_halted),
    .out_exit_code(out_exit_code), .out_illegal(out_illegal)
  );

endmodule
